// File: design/sitd_pkg.sv
`timescale 1ns / 1ps

package sitd_pkg;

   // Field widths of the two channels and of one digit.
   localparam int VALUE_W  = 64;
   localparam int SYMBOL_W = 8;
   localparam int DIGIT_W  = 4;

   // Magnitude bits taken into the digit row per conversion cycle.
   localparam int BITS_PER_STEP = 8;
   localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;

   // Digit positions: default and the hard upper bound.
   localparam int DEFAULT_MAX_DIGITS = 19;
   localparam int DIGIT_SLOTS        = 20;

   // ASCII codes that the block emits.
   localparam logic [SYMBOL_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [SYMBOL_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [SYMBOL_W-1:0] CHAR_MINUS = 8'h2D;

   // Per-cycle command to every cell of the digit row.
   typedef struct packed {
      logic clear;
      logic dabble;
      logic shift;
   } cell_ctl_type;

   // Number of digit positions actually built, clamped to 1..DIGIT_SLOTS.
   function automatic int eff_digits(int d);
      int n;
      n = d;
      if (n < 1) n = 1;
      if (n > DIGIT_SLOTS) n = DIGIT_SLOTS;
      return n;
   endfunction

   // Largest magnitude that fits in the given number of digits.
   function automatic logic [VALUE_W-1:0] mag_limit(int d);
      logic [VALUE_W-1:0] p;
      int n;
      n = eff_digits(d);
      p = {{(VALUE_W-1){1'b0}}, 1'b1};
      if (n >= DIGIT_SLOTS) return {VALUE_W{1'b1}};
      for (int i = 0; i < n; i++) p = p * VALUE_W'(10);
      return p - {{(VALUE_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

// File: design/signed_integer_to_decimal_text_unit.sv
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// req     | in        | req_valid/req_stall | req_value (64, signed)
// rsp     | out       | rsp_valid/rsp_stall | rsp_symbol (8), rsp_final_res (1)
//
// An accepted item goes through conversion, 8 magnitude bits per cycle, in a row
// of MAX_DIGITS (clamped to 1..20) shift-and-add-3 digit cells. The row then shifts
// toward the top, dropping leading zeros, one digit per cycle when rsp is not stalled.
// Reset is synchronous and clears the sequencer's control registers and the output valid flag.
// req_stall stays high until the last character is loaded; rsp stalls lengthen an item.

module signed_integer_to_decimal_text_unit #(
   parameter int MAX_DIGITS = sitd_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [sitd_pkg::VALUE_W-1:0]   req_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [sitd_pkg::SYMBOL_W-1:0]         rsp_symbol,
   output logic                                  rsp_final_res
);
   import sitd_pkg::*;

   localparam int ND    = eff_digits(MAX_DIGITS);
   localparam int REM_W = (ND > 1) ? $clog2(ND) : 1;
   localparam int CNT_W = $clog2(CONV_STEPS);
   localparam int K     = BITS_PER_STEP;
   localparam logic [VALUE_W-1:0] MAG_LIMIT = mag_limit(MAX_DIGITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic                started_ff, started_in;
   logic                sign_pend_ff, sign_pend_in;

   logic                rsp_valid_ff;
   logic [SYMBOL_W-1:0] rsp_symbol_ff;
   logic                rsp_final_res_ff;

   logic                out_free;
   logic                out_load;
   logic [SYMBOL_W-1:0] out_symbol;
   logic                out_final;
   logic                skip;

   logic [VALUE_W-1:0]  raw;
   logic [VALUE_W-1:0]  mag_abs;
   logic [VALUE_W-1:0]  mag_sat;

   cell_ctl_type        ctl;
   logic [K-1:0]        carry_chain [ND+1];
   logic [DIGIT_W-1:0]  digits      [ND];
   logic [DIGIT_W-1:0]  top_digit;

   // Magnitude of the incoming value, saturated to the digit count.
   assign raw     = $unsigned(req_value);
   assign mag_abs = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
   assign mag_sat = (mag_abs > MAG_LIMIT) ? MAG_LIMIT : mag_abs;

   // Row of digit cells; cell 0 is the least significant digit.
   assign carry_chain[0] = mag_ff[VALUE_W-1 -: K];

   for (genvar i = 0; i < ND; i++) begin : g_cell
      logic [DIGIT_W-1:0] low;
      if (i == 0) begin : g_bottom
         assign low = '0;
      end else begin : g_upper
         assign low = digits[i-1];
      end
      sitd_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .carry_in  (carry_chain[i]),
         .carry_out (carry_chain[i+1]),
         .low_digit (low),
         .digit     (digits[i])
      );
   end

   assign top_digit = digits[ND-1];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign skip      = !started_ff && (top_digit == '0) && (rem_ff != '0);

   // Sequencer: load, convert, then shift digits out of the top cell.
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rem_in       = rem_ff;
      started_in   = started_ff;
      sign_pend_in = sign_pend_ff;
      ctl          = '0;
      out_load     = 1'b0;
      out_symbol   = CHAR_ZERO;
      out_final    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in    = raw[VALUE_W-1];
               mag_in    = mag_sat;
               ctl.clear = 1'b1;
               cnt_in    = '0;
               state_in  = ST_CONV;
            end
         end
         ST_CONV: begin
            ctl.dabble = 1'b1;
            mag_in     = {mag_ff[VALUE_W-K-1:0], {K{1'b0}}};
            cnt_in     = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CONV_STEPS - 1)) begin
               state_in     = ST_EMIT;
               rem_in       = REM_W'(ND - 1);
               started_in   = 1'b0;
               sign_pend_in = neg_ff;
            end
         end
         ST_EMIT: begin
            // Leading zeros leave the row without a character.
            if (skip) begin
               ctl.shift = 1'b1;
               rem_in    = rem_ff - REM_W'(1);
            end
            if (sign_pend_ff) begin
               if (out_free) begin
                  out_load     = 1'b1;
                  out_symbol   = CHAR_MINUS;
                  sign_pend_in = 1'b0;
               end
            end else if (!skip && out_free) begin
               out_load   = 1'b1;
               out_symbol = CHAR_ZERO + {{(SYMBOL_W-DIGIT_W){1'b0}}, top_digit};
               out_final  = (rem_ff == '0);
               ctl.shift  = 1'b1;
               started_in = 1'b1;
               if (rem_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  rem_in = rem_ff - REM_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rem_ff       <= '0;
         started_ff   <= 1'b0;
         sign_pend_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rem_ff       <= rem_in;
         started_ff   <= started_in;
         sign_pend_ff <= sign_pend_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   // Output register holds one character until it is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_symbol_ff    <= out_symbol;
         rsp_final_res_ff <= out_final;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_symbol    = rsp_symbol_ff;
   assign rsp_final_res = rsp_final_res_ff;

endmodule

// File: design/sitd_cell.sv
`timescale 1ns / 1ps

module sitd_cell (
   input  logic                                 clock,
   input  sitd_pkg::cell_ctl_type               ctl,
   input  logic [sitd_pkg::BITS_PER_STEP-1:0]   carry_in,
   output logic [sitd_pkg::BITS_PER_STEP-1:0]   carry_out,
   input  logic [sitd_pkg::DIGIT_W-1:0]         low_digit,
   output logic [sitd_pkg::DIGIT_W-1:0]         digit
);
   import sitd_pkg::*;

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] work;
   logic [DIGIT_W-1:0] adj;

   // Shift-and-add-3 over the bits of one cycle, most significant first.
   // The bit pushed out of the top of this digit goes to the next cell.
   always_comb begin
      work = digit_ff;
      adj  = digit_ff;
      carry_out = '0;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         adj = (work >= DIGIT_W'(5)) ? work + DIGIT_W'(3) : work;
         carry_out[BITS_PER_STEP-1-j] = adj[DIGIT_W-1];
         work = {adj[DIGIT_W-2:0], carry_in[BITS_PER_STEP-1-j]};
      end
   end

   // Clear on a new item, convert, or take the digit from the cell below.
   always_comb begin
      priority if (ctl.clear) begin
         digit_in = '0;
      end else if (ctl.dabble) begin
         digit_in = work;
      end else if (ctl.shift) begin
         digit_in = low_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

// File: design/sitd_checker.sv
`timescale 1ns / 1ps

module sitd_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [sitd_pkg::SYMBOL_W-1:0] rsp_symbol,
   input logic                          rsp_final_res
);
   import sitd_pkg::*;

   // A stalled character holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol)
                                  && $stable(rsp_final_res))
      else $error("stalled rsp item changed");

   // One item at a time: after an accept the input side is stalled.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item accepted while converting");

   // Only a minus sign or a decimal digit leaves the block.
   a_symbol_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_symbol == CHAR_MINUS)
                    || ((rsp_symbol >= CHAR_ZERO) && (rsp_symbol <= CHAR_NINE)))
      else $error("rsp symbol is not a sign or digit");

   // The sign is always followed by at least one digit.
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_symbol == CHAR_MINUS) |-> !rsp_final_res)
      else $error("minus sign flagged as last character");

endmodule

bind signed_integer_to_decimal_text_unit sitd_checker u_sitd_checker (.*);
